// File: rtl/core/shdf_pkg.sv
// Shared types, constants and helper functions for the sum-hash duplicate flagger.
// Used by the hash unit, the compare cells, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package shdf_pkg;

  localparam int MAX_TUPLES_DEF = 64;
  localparam int MAX_POSITIONS  = 4;
  localparam int OFFSET_FIELDS  = 4;
  localparam int TOP_POSITIONS  = (MAX_POSITIONS < OFFSET_FIELDS) ? MAX_POSITIONS : OFFSET_FIELDS;

  localparam int HASH_W   = 35;
  localparam int TIDX_W   = 6;
  localparam int CFG_W    = 3;
  localparam int SEQ_W    = 16;
  localparam int STRAND_W = 2;
  localparam int OFS_W    = 32;

  localparam logic [CFG_W-1:0] POS_RESET = CFG_W'(4);

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_DRAIN,
    ST_OUTPUT
  } shdf_state_t;

  typedef struct packed {
    logic              valid;
    logic [TIDX_W-1:0] target;
    logic              hit;
    logic [HASH_W-1:0] hash;
  } shdf_pkt_t;

  function automatic logic [CFG_W-1:0] used_positions(input logic [CFG_W-1:0] cfg);
    logic [CFG_W-1:0] n;
    n = cfg;
    if (n == '0) begin
      n = CFG_W'(1);
    end
    if (n > CFG_W'(TOP_POSITIONS)) begin
      n = CFG_W'(TOP_POSITIONS);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/shdf_hash.sv
// Two-stage adder that turns one tuple into its exact 35-bit sum hash.
// Depends on shdf_pkg for field widths, the packet type and the position clamp.
`timescale 1ns / 1ps
`default_nettype none

module shdf_hash
  import shdf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                launch,
  input  wire logic [TIDX_W-1:0]   target,
  input  wire logic [CFG_W-1:0]    positions,
  input  wire logic [SEQ_W-1:0]    seq_id,
  input  wire logic [STRAND_W-1:0] strand_code,
  input  wire logic [OFS_W-1:0]    offset_a,
  input  wire logic [OFS_W-1:0]    offset_b,
  input  wire logic [OFS_W-1:0]    offset_c,
  input  wire logic [OFS_W-1:0]    offset_d,
  output shdf_pkt_t                pkt
);

  logic                s1_valid_r;
  logic [TIDX_W-1:0]   s1_target_r;
  logic [OFS_W:0]      s1_ab_r, s1_ab_nxt;
  logic [OFS_W:0]      s1_cd_r, s1_cd_nxt;
  logic [SEQ_W:0]      s1_id_r, s1_id_nxt;
  logic [CFG_W-1:0]    n_used;
  shdf_pkt_t           s2_r;
  logic [HASH_W-1:0]   hash_nxt;

  always_comb begin
    n_used    = used_positions(positions);
    s1_ab_nxt = {offset_a[OFS_W-1], offset_a}
              + ((n_used >= CFG_W'(2)) ? {offset_b[OFS_W-1], offset_b} : '0);
    s1_cd_nxt = ((n_used >= CFG_W'(3)) ? {offset_c[OFS_W-1], offset_c} : '0)
              + ((n_used >= CFG_W'(4)) ? {offset_d[OFS_W-1], offset_d} : '0);
    s1_id_nxt = {1'b0, seq_id} + (SEQ_W+1)'(strand_code);
    hash_nxt  = {{(HASH_W-OFS_W-1){s1_ab_r[OFS_W]}}, s1_ab_r}
              + {{(HASH_W-OFS_W-1){s1_cd_r[OFS_W]}}, s1_cd_r}
              + HASH_W'(s1_id_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_r.valid <= 1'b0;
    end else begin
      s1_valid_r <= launch;
      s2_r.valid <= s1_valid_r;
    end
    s1_target_r <= target;
    s1_ab_r     <= s1_ab_nxt;
    s1_cd_r     <= s1_cd_nxt;
    s1_id_r     <= s1_id_nxt;
    s2_r.target <= s1_target_r;
    s2_r.hit    <= 1'b0;
    s2_r.hash   <= hash_nxt;
  end

  assign pkt = s2_r;

endmodule

`default_nettype wire

// File: rtl/core/shdf_cell.sv
// One compare cell of the chain: holds one stored hash and its candidate mark.
// A packet passing through compares against the stored hash and is written here
// when it reaches its own slot. Depends on shdf_pkg for the packet type.
`timescale 1ns / 1ps
`default_nettype none

module shdf_cell
  import shdf_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire shdf_pkt_t pkt_in,
  output shdf_pkt_t      pkt_out,
  input  wire logic      shift_en,
  input  wire logic      mark_in,
  output wire logic      mark_out
);

  logic [HASH_W-1:0] hash_r;
  logic              mark_r, mark_nxt;
  shdf_pkt_t         pkt_r, pkt_nxt;
  logic              before_slot;
  logic              at_slot;
  logic              equal;

  always_comb begin
    before_slot = pkt_in.valid && (pkt_in.target > TIDX_W'(CELL_IDX));
    at_slot     = pkt_in.valid && (pkt_in.target == TIDX_W'(CELL_IDX));
    equal       = (pkt_in.hash == hash_r);
    mark_nxt    = mark_r;
    if (shift_en) begin
      mark_nxt = mark_in;
    end else if (before_slot && equal) begin
      mark_nxt = 1'b1;
    end else if (at_slot) begin
      mark_nxt = mark_r | pkt_in.hit;
    end
    pkt_nxt       = pkt_in;
    pkt_nxt.valid = before_slot;
    pkt_nxt.hit   = pkt_in.hit | (before_slot && equal);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r      <= 1'b0;
      pkt_r.valid <= 1'b0;
    end else begin
      mark_r      <= mark_nxt;
      pkt_r.valid <= pkt_nxt.valid;
    end
    pkt_r.target <= pkt_nxt.target;
    pkt_r.hit    <= pkt_nxt.hit;
    pkt_r.hash   <= pkt_nxt.hash;
    if (at_slot) begin
      hash_r <= pkt_in.hash;
    end
  end

  assign pkt_out  = pkt_r;
  assign mark_out = mark_r;

endmodule

`default_nettype wire

// File: rtl/core/sum_hash_duplicate_flagger.sv
// Top level of the sum-hash duplicate flagger: control, hash unit and cell chain.
// Depends on shdf_pkg, shdf_hash and shdf_cell.
//
// Usage: tuples arrive on the in_ channel (valid/stall), one transfer per cycle
// while a set is being loaded. Each tuple is hashed and then walks a chain of
// MAX_TUPLES compare cells, one cell per cycle, marking every stored tuple with
// an equal hash and landing in its own slot. Tuples beyond capacity are dropped
// and set the overflow flag for the set.
// The transfer carrying in_final_tuple closes the set. in_stall is then high
// until the set is read out. The first result is offered once the last stored
// hash has reached its slot. Then one result per stored tuple leaves on the
// out_ channel in load order, one per cycle while out_stall is low; a stalled
// result holds its payload. The readout shifts the marks along the chain, so
// the chain is clear again when the last result is taken, and the input
// reopens in the next cycle.
// Throughput: one tuple per cycle while loading.
// cfg_wr_en writes positions_in_use; the user must do so only at an idle time, which the block itself does not enforce.
// Reset (synchronous, rst_n low) empties the set and sets positions_in_use to 4.
`timescale 1ns / 1ps
`default_nettype none

module sum_hash_duplicate_flagger
  import shdf_pkg::*;
#(
  parameter int MAX_TUPLES = MAX_TUPLES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_W-1:0]    cfg_wr_data,
  input  wire logic                in_valid,
  output wire logic                in_stall,
  input  wire logic [SEQ_W-1:0]    in_seq_id,
  input  wire logic [STRAND_W-1:0] in_strand_code,
  input  wire logic [OFS_W-1:0]    in_offset_a,
  input  wire logic [OFS_W-1:0]    in_offset_b,
  input  wire logic [OFS_W-1:0]    in_offset_c,
  input  wire logic [OFS_W-1:0]    in_offset_d,
  input  wire logic                in_final_tuple,
  output wire logic                out_valid,
  input  wire logic                out_stall,
  output wire logic [TIDX_W-1:0]   out_tuple_index,
  output wire logic                out_is_candidate,
  output wire logic                out_overflowed,
  output wire logic                out_last_result
);

  localparam int IDX_W = $clog2(MAX_TUPLES);
  localparam int CNT_W = $clog2(MAX_TUPLES + 1);

  shdf_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] drain_r, drain_nxt;
  logic [IDX_W-1:0] oidx_r, oidx_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CFG_W-1:0] pos_r;

  logic             in_xfer;
  logic             out_xfer;
  logic             launch;
  logic             shift_en;
  logic             is_last;
  logic             stall_int;
  logic             valid_int;

  shdf_pkt_t        pkt_chain [MAX_TUPLES+1];
  logic             marks     [MAX_TUPLES];
  logic             shift_src [MAX_TUPLES];

  assign stall_int = (state_r != ST_ACCEPT);
  assign valid_int = (state_r == ST_OUTPUT);
  assign in_xfer   = in_valid && !stall_int;
  assign out_xfer  = valid_int && !out_stall;
  assign is_last   = ((CNT_W'(oidx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    drain_nxt = drain_r;
    oidx_nxt  = oidx_r;
    ovf_nxt   = ovf_r;
    launch    = 1'b0;
    shift_en  = 1'b0;
    case (state_r)
      ST_ACCEPT: begin
        if (in_xfer) begin
          if (count_r < CNT_W'(MAX_TUPLES)) begin
            launch    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final_tuple) begin
            state_nxt = ST_DRAIN;
            drain_nxt = count_nxt;
          end
        end
      end
      ST_DRAIN: begin
        if (drain_r != '0) begin
          drain_nxt = drain_r - CNT_W'(1);
        end else begin
          state_nxt = ST_OUTPUT;
          oidx_nxt  = '0;
        end
      end
      ST_OUTPUT: begin
        if (out_xfer) begin
          shift_en = 1'b1;
          if (is_last) begin
            state_nxt = ST_ACCEPT;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else begin
            oidx_nxt = oidx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCEPT;
      count_r <= '0;
      drain_r <= '0;
      oidx_r  <= '0;
      ovf_r   <= 1'b0;
      pos_r   <= POS_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drain_r <= drain_nxt;
      oidx_r  <= oidx_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_wr_en) begin
        pos_r <= cfg_wr_data;
      end
    end
  end

  shdf_hash u_hash (
    .clk         (clk),
    .rst_n       (rst_n),
    .launch      (launch),
    .target      (TIDX_W'(count_r[IDX_W-1:0])),
    .positions   (pos_r),
    .seq_id      (in_seq_id),
    .strand_code (in_strand_code),
    .offset_a    (in_offset_a),
    .offset_b    (in_offset_b),
    .offset_c    (in_offset_c),
    .offset_d    (in_offset_d),
    .pkt         (pkt_chain[0])
  );

  for (genvar k = 0; k < MAX_TUPLES; k++) begin : g_cell
    if (k == MAX_TUPLES - 1) begin : g_end
      assign shift_src[k] = 1'b0;
    end else begin : g_mid
      assign shift_src[k] = marks[k+1];
    end

    shdf_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .pkt_in   (pkt_chain[k]),
      .pkt_out  (pkt_chain[k+1]),
      .shift_en (shift_en),
      .mark_in  (shift_src[k]),
      .mark_out (marks[k])
    );
  end

  assign in_stall         = stall_int;
  assign out_valid        = valid_int;
  assign out_tuple_index  = TIDX_W'(oidx_r);
  assign out_is_candidate = marks[0];
  assign out_overflowed   = ovf_r;
  assign out_last_result  = is_last;

endmodule

`default_nettype wire

// File: rtl/core/shdf_checker.sv
// Port-level checker for the sum-hash duplicate flagger, bound to the top level.
// Depends on shdf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module shdf_checker
  import shdf_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                in_final_tuple,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [TIDX_W-1:0]   out_tuple_index,
  input wire logic                out_is_candidate,
  input wire logic                out_overflowed,
  input wire logic                out_last_result
);

  // Closing a set must stop the input; this checks that in_stall goes high after the final tuple.
  a_final_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_final_tuple |=> in_stall)
    else $error("input accepted right after the final tuple");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while results are pending");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_result |=>
      out_valid && (out_tuple_index == TIDX_W'($past(out_tuple_index) + TIDX_W'(1))))
    else $error("result index did not advance by one");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tuple_index)
      && $stable(out_is_candidate) && $stable(out_overflowed) && $stable(out_last_result))
    else $error("stalled result changed");

endmodule

bind sum_hash_duplicate_flagger shdf_checker u_shdf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_final_tuple   (in_final_tuple),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_tuple_index  (out_tuple_index),
  .out_is_candidate (out_is_candidate),
  .out_overflowed   (out_overflowed),
  .out_last_result  (out_last_result)
);

`default_nettype wire
